// ===== rtl/core/tiny_isa_execute_unit_assert.svh =====
// Assertion macros for the checker file of the execute unit.
`ifndef TINY_ISA_EXECUTE_UNIT_ASSERT_SVH
`define TINY_ISA_EXECUTE_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define TISA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tiny_isa_execute_unit: check failed");

// Checked on every rising edge, reset included.
`define TISA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("tiny_isa_execute_unit: check failed");

`endif

// ===== rtl/core/tisa_pkg.sv =====
package tisa_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned RegAw  = 2;
  localparam int unsigned MemAw  = 3;
  localparam int unsigned RegNum = 4;
  localparam int unsigned MemNum = 8;

  localparam logic [DataW-1:0] Reg0Reset = 8'd4;
  localparam logic [DataW-1:0] Reg3Reset = 8'd3;
  localparam logic [RegAw-1:0] Reg0Idx   = 2'd0;
  localparam logic [RegAw-1:0] Reg1Idx   = 2'd1;
  localparam logic [RegAw-1:0] Reg3Idx   = 2'd3;

  // Codes of the mapped register numbering.
  localparam logic [RegAw-1:0] MapR0Code = 2'b01;
  localparam logic [RegAw-1:0] MapR1Code = 2'b11;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MOV = 3'd1,
    OP_SUB = 3'd2,
    OP_LD  = 3'd3,
    OP_ST  = 3'd4,
    OP_JMP = 3'd5,
    OP_JZ  = 3'd6,
    OP_HLT = 3'd7
  } opcode_e;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [DataW-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [DataW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [DataW-1:0] next_pc;
    logic             reg_written;
    logic [RegAw-1:0] reg_index;
    logic [DataW-1:0] reg_value;
    logic             mem_written;
    logic [MemAw-1:0] mem_addr;
    logic [DataW-1:0] mem_value;
    logic             jumped;
    logic             halted;
  } result_t;

  function automatic logic [DataW-1:0] reg_reset_val(input logic [RegAw-1:0] idx);
    logic [DataW-1:0] val;
    case (idx)
      Reg0Idx: val = Reg0Reset;
      Reg3Idx: val = Reg3Reset;
      default: val = '0;
    endcase
    return val;
  endfunction

  function automatic logic [RegAw-1:0] map_reg(input logic mode,
                                               input logic [RegAw-1:0] field);
    logic [RegAw-1:0] idx;
    if (!mode) begin
      idx = field;
    end else if (field == MapR1Code) begin
      idx = Reg1Idx;
    end else begin
      // MapR0Code and the two unused codes all land on R0.
      idx = Reg0Idx;
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/tiny_isa_execute_unit.sv =====
// A taken item is read from the registered memories, then executed into the output register.
// Throughput: one item per cycle unless the output stalls; the register file and data
// memory read ports are registered; the write in execute is forwarded into the next reads.
// Reset: counter 0, halt flag clear, operand_mode 1; R0 reads 4, R3 reads 3, all else 0,
// through per-entry valid bits, so the block is ready in the first cycle after reset.
module tiny_isa_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] instruction
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] next_pc, [9:8] reg_index, [17:10] reg_value, [20:18] mem_addr,
  // [28:21] mem_value, [31:29] zero
  output logic [31:0] m_axis_tdata_o,
  // [0] reg_written, [1] mem_written, [2] jumped, [3] halted
  output logic [3:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // operand_mode
);
  import tisa_pkg::*;

  logic             operand_mode_q;
  logic             rd_en;
  logic [RegAw-1:0] raddr_a, raddr_b;
  logic [MemAw-1:0] maddr;
  logic [DataW-1:0] rdata_a, rdata_b, mdata;
  rf_wr_t           rf_wr;
  mem_wr_t          mem_wr;
  result_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operand_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      operand_mode_q <= cfg_data_i;
    end
  end

  tisa_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .wr_i      (rf_wr),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  tisa_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (rd_en),
    .raddr_i (maddr),
    .wr_i    (mem_wr),
    .rdata_o (mdata)
  );

  tisa_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .instr_i     (s_axis_tdata_i),
    .mode_i      (operand_mode_q),
    .rd_en_o     (rd_en),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .maddr_o     (maddr),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .mdata_i     (mdata),
    .rf_wr_o     (rf_wr),
    .mem_wr_o    (mem_wr),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {3'b000, res.mem_value, res.mem_addr, res.reg_value,
                           res.reg_index, res.next_pc};
  assign m_axis_tuser_o = {res.halted, res.jumped, res.mem_written, res.reg_written};

endmodule

// ===== rtl/core/tisa_regfile.sv =====
module tisa_regfile (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [tisa_pkg::RegAw-1:0]      raddr_a_i,
  input  logic [tisa_pkg::RegAw-1:0]      raddr_b_i,
  input  tisa_pkg::rf_wr_t                wr_i,
  output logic [tisa_pkg::DataW-1:0]      rdata_a_o,
  output logic [tisa_pkg::DataW-1:0]      rdata_b_o
);
  import tisa_pkg::*;

  logic [DataW-1:0]  mem_q [RegNum];
  logic [RegNum-1:0] valid_q;
  logic [DataW-1:0]  rdata_a_q;
  logic [DataW-1:0]  rdata_b_q;

  // An entry never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // The write landing at this edge is forwarded into the read register.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == raddr_a_i)) begin
        rdata_a_q <= wr_i.data;
      end else if (valid_q[raddr_a_i]) begin
        rdata_a_q <= mem_q[raddr_a_i];
      end else begin
        rdata_a_q <= reg_reset_val(raddr_a_i);
      end
      if (wr_i.en && (wr_i.addr == raddr_b_i)) begin
        rdata_b_q <= wr_i.data;
      end else if (valid_q[raddr_b_i]) begin
        rdata_b_q <= mem_q[raddr_b_i];
      end else begin
        rdata_b_q <= reg_reset_val(raddr_b_i);
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/core/tisa_dmem.sv =====
module tisa_dmem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [tisa_pkg::MemAw-1:0]      raddr_i,
  input  tisa_pkg::mem_wr_t               wr_i,
  output logic [tisa_pkg::DataW-1:0]      rdata_o
);
  import tisa_pkg::*;

  logic [DataW-1:0]  mem_q [MemNum];
  logic [MemNum-1:0] valid_q;
  logic [DataW-1:0]  rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == raddr_i)) begin
        rdata_q <= wr_i.data;
      end else if (valid_q[raddr_i]) begin
        rdata_q <= mem_q[raddr_i];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tisa_exec.sv =====
module tisa_exec (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      instr_i,
  input  logic                            mode_i,
  output logic                            rd_en_o,
  output logic [tisa_pkg::RegAw-1:0]      raddr_a_o,
  output logic [tisa_pkg::RegAw-1:0]      raddr_b_o,
  output logic [tisa_pkg::MemAw-1:0]      maddr_o,
  input  logic [tisa_pkg::DataW-1:0]      rdata_a_i,
  input  logic [tisa_pkg::DataW-1:0]      rdata_b_i,
  input  logic [tisa_pkg::DataW-1:0]      mdata_i,
  output tisa_pkg::rf_wr_t                rf_wr_o,
  output tisa_pkg::mem_wr_t               mem_wr_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tisa_pkg::result_t               out_o
);
  import tisa_pkg::*;

  logic             accept;
  logic             advance;
  logic             s1_valid_q;
  opcode_e          opcode_q;
  logic [RegAw-1:0] rd_q;
  logic [MemAw-1:0] op2_q;
  logic [DataW-1:0] pc_q, pc_d;
  logic             halt_q, halt_d;
  logic             out_valid_q;
  result_t          out_q;
  result_t          res;
  logic             jmp;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // Read addresses go to the memories in the cycle the item is taken.
  assign rd_en_o   = accept;
  assign raddr_a_o = map_reg(mode_i, instr_i[4:3]);
  assign raddr_b_o = instr_i[1:0];
  assign maddr_o   = instr_i[2:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= opcode_e'(instr_i[7:5]);
      rd_q     <= map_reg(mode_i, instr_i[4:3]);
      op2_q    <= instr_i[2:0];
    end
  end

  always_comb begin
    res    = '0;
    jmp    = 1'b0;
    halt_d = halt_q;
    if (halt_q) begin
      res.next_pc = pc_q;
      res.halted  = 1'b1;
      pc_d        = pc_q;
    end else begin
      unique case (opcode_q)
        OP_ADD: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd_q;
          res.reg_value   = rdata_a_i + rdata_b_i;
        end
        OP_MOV: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd_q;
          res.reg_value   = {{(DataW-MemAw){1'b0}}, op2_q};
        end
        OP_SUB: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd_q;
          res.reg_value   = rdata_a_i - rdata_b_i;
        end
        OP_LD: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd_q;
          res.reg_value   = mdata_i;
          res.mem_addr    = op2_q;
        end
        OP_ST: begin
          res.mem_written = 1'b1;
          res.mem_addr    = op2_q;
          res.mem_value   = rdata_a_i;
        end
        OP_JMP: jmp = 1'b1;
        OP_JZ: begin
          res.reg_index = rd_q;
          jmp           = (rdata_a_i == '0);
        end
        OP_HLT: halt_d = 1'b1;
        default: ;
      endcase
      pc_d        = jmp ? {{(DataW-MemAw){1'b0}}, op2_q} : pc_q + 8'd1;
      res.next_pc = pc_d;
      res.jumped  = jmp;
      res.halted  = halt_d;
    end
  end

  assign rf_wr_o.en    = advance && res.reg_written;
  assign rf_wr_o.addr  = res.reg_index;
  assign rf_wr_o.data  = res.reg_value;
  assign mem_wr_o.en   = advance && res.mem_written;
  assign mem_wr_o.addr = op2_q;
  assign mem_wr_o.data = rdata_a_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
        halt_q      <= halt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/tisa_checker.sv =====
module tisa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);

`include "tiny_isa_execute_unit_assert.svh"

  // A result waiting on the output holds still.
  `TISA_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // A jump target comes from the three-bit operand.
  `TISA_ASSERT(a_jump_target, m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tdata_o[7:3] == 5'd0)

  // A halted result writes nothing and does not jump.
  `TISA_ASSERT(a_halt_quiet, m_axis_tvalid_o && m_axis_tuser_o[3] |-> m_axis_tuser_o[2:0] == 3'd0)

  // A store never also writes a register.
  `TISA_ASSERT(a_store_only, m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0] && m_axis_tdata_o[17:8] == 10'd0)

  // The output valid register is also cleared by the reset edge, so the check looks in the next cycle.
  `TISA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind tiny_isa_execute_unit tisa_checker u_tisa_checker (.*);
